// ===== design/vfpd_pkg.sv =====
package vfpd_pkg;

    localparam int CFG_AW = 3;
    localparam int PT_W   = 112;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MIN_X,
        CFG_MIN_Y,
        CFG_MIN_Z,
        CFG_MAX_X,
        CFG_MAX_Y,
        CFG_MAX_Z,
        CFG_RES,
        CFG_GRID
    } t_cfg_idx;

    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic [15:0]        res;
        logic [23:0]        dims;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        refl;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_point;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CHK,
        F_DIV,
        F_MUL1,
        F_MUL2,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLR,
        B_IDLE,
        B_CHK
    } t_bstate;

endpackage

// ===== design/vfpd_ram.sv =====
module vfpd_ram #(
    parameter int W  = 64,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== design/vfpd_fifo.sv =====
module vfpd_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

// ===== design/vfpd_front.sv =====
module vfpd_front #(
    parameter int MAX_SIDE = 64,
    parameter int CW       = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vfpd_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_type,
    input  vfpd_pkg::t_point      i_pt,
    output logic                  o_push,
    input  logic                  i_full,
    output logic                  o_clr,
    output logic                  o_ok,
    output logic [3*CW-1:0]       o_idx,
    output vfpd_pkg::t_point      o_pt
);
    import vfpd_pkg::*;

    localparam int NW = $clog2(MAX_SIDE + 1);
    localparam int DW = CW + 16;
    localparam int SW = (CW > 1) ? $clog2(CW) : 1;
    localparam int IW = 3 * CW;

    t_fstate r_state, n_state;
    logic             r_type;
    t_point           r_pt;
    logic [2:0]       r_ok;
    logic [DW-1:0]    r_rem [3];
    logic [CW-1:0]    r_q   [3];
    logic [SW-1:0]    r_step;
    logic [2*CW-1:0]  r_t;
    logic [IW-1:0]    r_idx;

    logic [15:0]        res_eff;
    logic [NW-1:0]      cnt [3];
    logic [7:0]         raw [3];
    logic signed [31:0] pos [3];
    logic signed [31:0] lo  [3];
    logic signed [31:0] hi  [3];
    logic signed [32:0] off [3];
    logic [NW+15:0]     lim [3];
    logic [2:0]         ok;
    logic [DW-1:0]      dsh;
    logic [CW+NW-1:0]   m1;
    logic [2*CW+NW-1:0] m2;

    always_comb begin
        res_eff = (i_cfg.res == 16'd0) ? 16'd1 : i_cfg.res;
        raw[0] = i_cfg.dims[7:0];
        raw[1] = i_cfg.dims[15:8];
        raw[2] = i_cfg.dims[23:16];
        pos[0] = r_pt.x;     pos[1] = r_pt.y;     pos[2] = r_pt.z;
        lo[0]  = i_cfg.min_x; lo[1] = i_cfg.min_y; lo[2] = i_cfg.min_z;
        hi[0]  = i_cfg.max_x; hi[1] = i_cfg.max_y; hi[2] = i_cfg.max_z;
        for (int a = 0; a < 3; a++) begin
            cnt[a] = (32'(raw[a]) > MAX_SIDE) ? NW'(MAX_SIDE) : NW'(raw[a]);
            off[a] = {pos[a][31], pos[a]} - {lo[a][31], lo[a]};
            lim[a] = cnt[a] * res_eff;
            ok[a]  = (pos[a] >= lo[a]) && (pos[a] < hi[a]) &&
                     (off[a][31:0] < 32'(lim[a]));
        end
        dsh = DW'(res_eff) << r_step;
        m1  = r_q[2] * cnt[1];
        m2  = r_t * cnt[0];
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = (i_type == REQ_CLEAR) ? F_PUSH : F_CHK;
                end
            end
            F_CHK:  n_state = F_DIV;
            F_DIV: begin
                if (r_step == '0) begin
                    n_state = F_MUL1;
                end
            end
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_type <= i_type;
                r_pt   <= i_pt;
                r_ok   <= 3'b000;
            end
            F_CHK: begin
                r_ok   <= ok;
                r_step <= SW'(CW - 1);
                for (int a = 0; a < 3; a++) begin
                    r_rem[a] <= off[a][DW-1:0];
                    r_q[a]   <= '0;
                end
            end
            F_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    if (r_rem[a] >= dsh) begin
                        r_rem[a]       <= r_rem[a] - dsh;
                        r_q[a][r_step] <= 1'b1;
                    end
                end
                r_step <= r_step - SW'(1);
            end
            F_MUL1: r_t   <= (2*CW)'(m1) + (2*CW)'(r_q[1]);
            F_MUL2: r_idx <= IW'(m2) + IW'(r_q[0]);
            default: ;
        endcase
    end

    assign o_clr = (r_type == REQ_CLEAR);
    assign o_ok  = &r_ok;
    assign o_idx = r_idx;
    assign o_pt  = r_pt;
endmodule

// ===== design/vfpd_back.sv =====
module vfpd_back #(
    parameter int CW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  logic             i_clr,
    input  logic             i_ok,
    input  logic [3*CW-1:0]  i_idx,
    input  vfpd_pkg::t_point i_pt,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_keep,
    output logic             o_any,
    output vfpd_pkg::t_point o_pt
);
    import vfpd_pkg::*;

    localparam int IW    = 3 * CW;
    localparam int RB    = (IW > 7) ? 6 : IW - 1;
    localparam int ROW_W = 2 ** RB;
    localparam int AW    = IW - RB;

    t_bstate r_state, n_state;
    logic [AW-1:0]    r_caddr;
    logic [AW-1:0]    r_addr;
    logic [RB-1:0]    r_bit;
    t_point           r_jpt;
    logic             r_valid;
    logic             r_keep;
    logic             r_any;
    t_point           r_pt;

    logic             out_free;
    logic             we, re;
    logic [AW-1:0]    waddr;
    logic [ROW_W-1:0] wdata, rdata;
    logic             load, n_keep, n_any;
    t_point           n_pt;

    vfpd_ram #(.W(ROW_W), .AW(AW)) u_occ (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (i_idx[IW-1:RB]),
        .o_rdata (rdata)
    );

    always_comb begin
        out_free = !r_valid || i_ready;
        n_state  = r_state;
        o_pop    = 1'b0;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = r_addr;
        wdata    = '0;
        load     = 1'b0;
        n_keep   = 1'b0;
        n_any    = r_any;
        n_pt     = '0;
        case (r_state)
            B_CLR: begin
                we    = 1'b1;
                waddr = r_caddr;
                if (&r_caddr) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_clr) begin
                        load    = 1'b1;
                        n_state = B_CLR;
                    end else if (!i_ok) begin
                        load = 1'b1;
                    end else begin
                        re      = 1'b1;
                        n_state = B_CHK;
                    end
                end
            end
            B_CHK: begin
                load    = 1'b1;
                n_state = B_IDLE;
                if (!rdata[r_bit]) begin
                    we     = 1'b1;
                    wdata  = rdata | (ROW_W'(1) << r_bit);
                    n_keep = 1'b1;
                    n_any  = 1'b1;
                    n_pt   = r_jpt;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLR;
            r_caddr <= '0;
            r_valid <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) begin
                r_caddr <= r_caddr + AW'(1);
            end else begin
                r_caddr <= '0;
            end
            if (load) begin
                r_valid <= 1'b1;
                r_any   <= n_any;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= i_idx[IW-1:RB];
            r_bit  <= i_idx[RB-1:0];
            r_jpt  <= i_pt;
        end
        if (load) begin
            r_keep <= n_keep;
            r_pt   <= n_pt;
        end
    end

    assign o_valid = r_valid;
    assign o_keep  = r_keep;
    assign o_any   = r_any;
    assign o_pt    = r_pt;
endmodule

// ===== design/voxel_first_point_decimator_core.sv =====
// Voxel first-point decimator. Each request word either tests a point (tuser 0) or empties
// the occupancy store (tuser 1); every request yields exactly one result word. A point
// is kept when it lies in the configured box, its bins are below the grid counts and
// its voxel is still empty. The front end takes one request at a time: a point passes the
// box check, the bin divider (one quotient bit per cycle in each of the three axis lanes),
// two multiply-add steps and a push into the queue, which waits while the queue is full; a
// clear request goes straight to the push. A two-word queue feeds the back end, which
// passes a point outside the grid on without a memory access and does an occupancy
// read-modify-write for a point inside it. After reset and after every clear request the
// back end sweeps the occupancy memory, one row a cycle (64 bits by 4096 rows at 64); points
// queue up meanwhile. Write the configuration only while the block is idle.
module voxel_first_point_decimator_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,   // pos_x, pos_y, pos_z, reflectance
    input  logic [0:0]   i_s_tuser,   // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,   // out_x, out_y, out_z, out_reflectance
    output logic [1:0]   o_m_tuser,   // keep, any_kept
    input  logic         i_cfg_we,
    input  logic [vfpd_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);
    import vfpd_pkg::*;

    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int IW = 3 * CW;
    localparam int JW = 2 + IW + PT_W;

    t_cfg          r_cfg;
    logic          push, full, pop, q_valid;
    logic          f_clr, f_ok, b_clr, b_ok;
    logic [IW-1:0] f_idx, b_idx;
    t_point        f_pt, b_pt, o_pt;
    logic          keep, any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x <= 32'sd0;
            r_cfg.min_y <= 32'sd0;
            r_cfg.min_z <= 32'sd0;
            r_cfg.max_x <= 32'sd64000;
            r_cfg.max_y <= 32'sd64000;
            r_cfg.max_z <= 32'sd64000;
            r_cfg.res   <= 16'd1000;
            r_cfg.dims  <= 24'h404040;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_X: r_cfg.min_x <= i_cfg_wdata;
                CFG_MIN_Y: r_cfg.min_y <= i_cfg_wdata;
                CFG_MIN_Z: r_cfg.min_z <= i_cfg_wdata;
                CFG_MAX_X: r_cfg.max_x <= i_cfg_wdata;
                CFG_MAX_Y: r_cfg.max_y <= i_cfg_wdata;
                CFG_MAX_Z: r_cfg.max_z <= i_cfg_wdata;
                CFG_RES:   r_cfg.res   <= i_cfg_wdata[15:0];
                CFG_GRID:  r_cfg.dims  <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    vfpd_front #(.MAX_SIDE(MAX_SIDE), .CW(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_type  (i_s_tuser[0]),
        .i_pt    (t_point'(i_s_tdata)),
        .o_push  (push),
        .i_full  (full),
        .o_clr   (f_clr),
        .o_ok    (f_ok),
        .o_idx   (f_idx),
        .o_pt    (f_pt)
    );

    vfpd_fifo #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_clr, f_ok, f_idx, f_pt}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  ({b_clr, b_ok, b_idx, b_pt})
    );

    vfpd_back #(.CW(CW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_clr   (b_clr),
        .i_ok    (b_ok),
        .i_idx   (b_idx),
        .i_pt    (b_pt),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_keep  (keep),
        .o_any   (any),
        .o_pt    (o_pt)
    );

    assign o_m_tdata = o_pt;
    assign o_m_tuser = {any, keep};

    a_keep_sets_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tuser[1])
        else $error("kept point without any_kept");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("dropped point carries data");

    a_any_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(any) |-> any)
        else $error("any_kept fell");

    a_no_pop_full_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue overflow");
endmodule

// ===== dv/voxel_first_point_decimator_core_tb.sv =====
module voxel_first_point_decimator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vfpd_pkg::*;

    localparam int SIDE      = 64;
    localparam int VOX_COUNT = SIDE * SIDE * SIDE;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic               keep;
        logic               any_kept;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        refl;
    } t_outcome;

    // Predicts decimator results and checks returned words in order.
    class voxel_scoreboard;
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic [15:0]        res;
        logic [23:0]        dims;
        bit                 occupied [];
        bit                 any_hit;
        t_outcome           pending [$];
        int                 errors;

        function void reset_state();
            occupied = new[VOX_COUNT];
            any_hit = 0;
            errors = 0;
            pending.delete();
            foreach (lo[a]) lo[a] = 0;
            foreach (hi[a]) hi[a] = 64000;
            res = 1000;
            dims = 24'h404040;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_MIN_X: lo[0] = v;
                CFG_MIN_Y: lo[1] = v;
                CFG_MIN_Z: lo[2] = v;
                CFG_MAX_X: hi[0] = v;
                CFG_MAX_Y: hi[1] = v;
                CFG_MAX_Z: hi[2] = v;
                CFG_RES:   res = v[15:0];
                CFG_GRID:  dims = v[23:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic req, logic [111:0] d);
            t_outcome o;
            logic signed [31:0] p [3];
            longint cnt [3];
            longint bin [3];
            longint off, r, idx;
            bit in_grid;
            o = '0;
            p[0] = d[31:0];
            p[1] = d[63:32];
            p[2] = d[95:64];
            if (req == REQ_CLEAR) begin
                foreach (occupied[i]) occupied[i] = 0;
            end else begin
                r = (res == 0) ? 1 : res;
                in_grid = 1;
                for (int a = 0; a < 3; a++) begin
                    cnt[a] = dims[8*a +: 8];
                    if (cnt[a] > SIDE) cnt[a] = SIDE;
                    if (p[a] < lo[a] || p[a] >= hi[a]) begin
                        in_grid = 0;
                        bin[a] = 0;
                    end else begin
                        off = longint'(p[a]) - longint'(lo[a]);
                        bin[a] = off / r;
                        if (bin[a] >= cnt[a]) in_grid = 0;
                    end
                end
                if (in_grid) begin
                    idx = bin[2] * cnt[0] * cnt[1] + bin[1] * cnt[0] + bin[0];
                    if (idx < VOX_COUNT && !occupied[idx]) begin
                        occupied[idx] = 1;
                        any_hit = 1;
                        o.keep = 1;
                        o.x = p[0];
                        o.y = p[1];
                        o.z = p[2];
                        o.refl = d[111:96];
                    end
                end
            end
            o.any_kept = any_hit;
            pending.push_back(o);
        endfunction

        function void check_result(logic [111:0] d, logic [1:0] u);
            t_outcome e;
            if (pending.size() == 0) begin
                $error("result word with no expectation");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (u[0] !== e.keep) begin
                $error("keep exp %0d got %0d", e.keep, u[0]); errors++;
            end
            if (u[1] !== e.any_kept) begin
                $error("any_kept exp %0d got %0d", e.any_kept, u[1]); errors++;
            end
            if (d[31:0] !== e.x) begin
                $error("out_x exp %0d got %0d", e.x, $signed(d[31:0])); errors++;
            end
            if (d[63:32] !== e.y) begin
                $error("out_y exp %0d got %0d", e.y, $signed(d[63:32])); errors++;
            end
            if (d[95:64] !== e.z) begin
                $error("out_z exp %0d got %0d", e.z, $signed(d[95:64])); errors++;
            end
            if (d[111:96] !== e.refl) begin
                $error("out_reflectance exp %0d got %0d", e.refl, d[111:96]); errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we = 0;
    logic [CFG_AW-1:0] cfg_idx = '0;
    logic [31:0]  cfg_wdata = '0;

    voxel_scoreboard sb = new();
    longint cycles = 0;
    bit     long_hold = 0;
    bit     sink_random = 1;

    always #6 i_clk = ~i_clk;

    voxel_first_point_decimator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** voxel_first_point_decimator_core: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // result sink: random stalls, optionally one long hold-off
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end
            w = sink_random ? $urandom_range(0, 15) : 0;
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_tready <= 1;
            @(posedge i_clk);
        end
    end

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic send(logic req, logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] z, logic [15:0] refl, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 15) : 0;
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {refl, z, y, x};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request(req, {refl, z, y, x});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] coord(logic signed [31:0] l, int span);
        int m;
        m = $urandom_range(0, 19);
        if (m == 0) return $urandom;
        if (m == 1) return l - $urandom_range(0, 3);
        return l + $urandom_range(0, span);
    endfunction

    task automatic random_phase(int n, int span, bit gaps);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 40) == 0)
                send(REQ_CLEAR, $urandom, $urandom, $urandom, 16'($urandom), gaps);
            else
                send(REQ_POINT, coord(sb.lo[0], span), coord(sb.lo[1], span),
                     coord(sb.lo[2], span), 16'($urandom), gaps);
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed, reset configuration
        send(REQ_POINT, 0, 0, 0, 16'hFFFF, 0);
        send(REQ_POINT, 999, 999, 999, 16'h0000, 0);
        send(REQ_POINT, 1000, 0, 0, 16'h1234, 0);
        send(REQ_POINT, 63999, 63999, 63999, 16'h8001, 0);
        send(REQ_POINT, 64000, 0, 0, 1, 0);
        send(REQ_POINT, -1, 0, 0, 2, 0);
        send(REQ_POINT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 3, 0);
        send(REQ_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 4, 0);
        send(REQ_POINT, -32'sd1, -32'sd1, -32'sd1, 16'hFFFF, 0);
        send(REQ_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 0);
        send(REQ_POINT, 0, 0, 0, 5, 0);
        drain();

        // zero resolution, oversize and zero grid counts, empty box
        write_cfg(CFG_RES, 0);
        write_cfg(CFG_GRID, 32'h00FF0203);
        send(REQ_POINT, 2, 1, 500, 6, 0);
        send(REQ_POINT, 3, 1, 63, 7, 0);
        drain();
        write_cfg(CFG_GRID, 32'h00040400);
        send(REQ_POINT, 0, 0, 0, 8, 0);
        drain();
        write_cfg(CFG_GRID, 32'h00404040);
        write_cfg(CFG_MIN_X, 100);
        write_cfg(CFG_MAX_X, 100);
        send(REQ_POINT, 100, 5, 5, 9, 0);
        drain();

        // extreme box, large resolution
        write_cfg(CFG_MIN_X, 32'h80000000);
        write_cfg(CFG_MIN_Y, 32'h80000000);
        write_cfg(CFG_MIN_Z, 32'h80000000);
        write_cfg(CFG_MAX_X, 32'h7FFFFFFF);
        write_cfg(CFG_MAX_Y, 32'h7FFFFFFF);
        write_cfg(CFG_MAX_Z, 32'h7FFFFFFF);
        write_cfg(CFG_RES, 32'h0000FFFF);
        send(REQ_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 10, 0);
        send(REQ_POINT, 32'sh7FFFFFFE, 0, 0, 11, 0);
        send(REQ_POINT, -32'sd1000, 32'sd4000000, 32'sd5, 12, 0);
        random_phase(60, 32'h7FFFFFFF, 1);
        drain();

        // small dense grid so voxels fill up; receiver holds off once
        write_cfg(CFG_MIN_X, -200);
        write_cfg(CFG_MIN_Y, 50);
        write_cfg(CFG_MIN_Z, -7);
        write_cfg(CFG_MAX_X, 1000);
        write_cfg(CFG_MAX_Y, 900);
        write_cfg(CFG_MAX_Z, 400);
        write_cfg(CFG_RES, 37);
        write_cfg(CFG_GRID, 32'h000A1F15);
        long_hold = 1;
        random_phase(40, 1100, 0);
        random_phase(240, 1100, 1);
        drain();

        // full-size grid, unit voxels, no idling, then random gaps
        write_cfg(CFG_MIN_X, 0);
        write_cfg(CFG_MIN_Y, 0);
        write_cfg(CFG_MIN_Z, 0);
        write_cfg(CFG_MAX_X, 64);
        write_cfg(CFG_MAX_Y, 64);
        write_cfg(CFG_MAX_Z, 64);
        write_cfg(CFG_RES, 1);
        write_cfg(CFG_GRID, 32'h00404040);
        sink_random = 0;
        random_phase(150, 70, 0);
        sink_random = 1;
        random_phase(150, 70, 1);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** voxel_first_point_decimator_core: PASSED **");
        else
            $display("** voxel_first_point_decimator_core: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
design/vfpd_pkg.sv
design/vfpd_ram.sv
design/vfpd_fifo.sv
design/vfpd_front.sv
design/vfpd_back.sv
design/voxel_first_point_decimator_core.sv
dv/voxel_first_point_decimator_core_tb.sv
